// ===== design/sbped_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral band peak event detector package
// Shared field widths, the event register layout and the item types that
// pass between the front end, the frame queue and the back end.
// ----------------------------------------------------------------------------
package sbped_pkg;

  localparam int MAX_EVENTS = 8;
  localparam int EVT_W      = 3;
  localparam int BIN_W      = 10;
  localparam int MAG_W      = 16;
  localparam int CD_CFG_W   = 16;
  localparam int CFG_W      = 53;

  // One event register, least significant field last.
  typedef struct packed {
    logic [CD_CFG_W-1:0] cooldown;
    logic [MAG_W-1:0]    threshold;
    logic [BIN_W-1:0]    max_bin;
    logic [BIN_W-1:0]    min_bin;
    logic                enable;
  } ev_cfg_t;

  // Snapshot of all events that fired at the end of one frame.
  typedef struct packed {
    logic [MAX_EVENTS-1:0]            mask;
    logic [MAX_EVENTS-1:0][BIN_W-1:0] bin;
    logic [MAX_EVENTS-1:0][MAG_W-1:0] value;
  } frame_t;

  typedef struct packed {
    logic [EVT_W-1:0] event_index;
    logic [BIN_W-1:0] peak_bin;
    logic [MAG_W-1:0] peak_value;
    logic             last_of_run;
  } result_t;

endpackage

// ===== design/sbped_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out store of DEPTH entries; flags decode a registered count.
// ----------------------------------------------------------------------------
module sbped_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] data_in,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] data_out
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== design/sbped_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector front end
// Holds the event registers and cooldown counters, tracks the peak of every
// event in parallel on each bin, and snapshots the fired events at frame end.
// ----------------------------------------------------------------------------
module sbped_front #(
  parameter int NUM_EVENTS    = 8,
  parameter int NUM_BINS      = 1024,
  parameter int SAMPLE_BITS   = 16,
  parameter int COOLDOWN_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         action,
  input  logic [sbped_pkg::BIN_W-1:0]  bin_index,
  input  logic [sbped_pkg::MAG_W-1:0]  magnitude,
  input  logic                         frame_end,
  input  logic                         wr_en,
  input  logic [sbped_pkg::EVT_W-1:0]  wr_addr,
  input  logic [sbped_pkg::CFG_W-1:0]  wr_data,
  output logic                         fq_push,
  output sbped_pkg::frame_t            fq_frame
);

  import sbped_pkg::*;

  localparam logic [MAG_W-1:0] MAG_MASK = MAG_W'((33'd1 << SAMPLE_BITS) - 33'd1);
  localparam logic [31:0]      CD_MAX   = 32'((33'd1 << COOLDOWN_BITS) - 33'd1);

  ev_cfg_t                  ev_cfg     [NUM_EVENTS];
  logic [COOLDOWN_BITS-1:0] cooldown   [NUM_EVENTS];
  logic [BIN_W-1:0]         best_bin   [NUM_EVENTS];
  logic [MAG_W-1:0]         best_value [NUM_EVENTS];
  logic [NUM_EVENTS-1:0]    peak_found;

  logic [MAG_W-1:0]         mag;
  logic                     bin_ok;
  logic                     is_bin;
  logic                     is_tick;
  logic                     closing;
  logic [NUM_EVENTS-1:0]    hit;
  logic [NUM_EVENTS-1:0]    fire;
  logic [COOLDOWN_BITS-1:0] reload [NUM_EVENTS];

  assign mag     = magnitude & MAG_MASK;
  assign bin_ok  = 32'(bin_index) < 32'(NUM_BINS);
  assign is_bin  = accept && action;
  assign is_tick = accept && !action;
  assign closing = is_bin && frame_end;

  always_comb begin
    logic [31:0] cd_wide;
    fq_frame = '0;
    for (int e = 0; e < NUM_EVENTS; e++) begin
      hit[e] = is_bin && bin_ok && ev_cfg[e].enable && (cooldown[e] == '0)
               && (bin_index >= ev_cfg[e].min_bin) && (bin_index <= ev_cfg[e].max_bin)
               && (mag >= ev_cfg[e].threshold) && (mag != '0)
               && (!peak_found[e] || (mag > best_value[e]));
      fire[e] = ev_cfg[e].enable && (hit[e] || peak_found[e]);
      cd_wide = 32'(ev_cfg[e].cooldown);
      reload[e] = COOLDOWN_BITS'((cd_wide > CD_MAX) ? CD_MAX : cd_wide);
      fq_frame.mask[e]  = fire[e];
      fq_frame.bin[e]   = hit[e] ? bin_index : best_bin[e];
      fq_frame.value[e] = hit[e] ? mag : best_value[e];
    end
  end

  assign fq_push = closing && (fire != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < NUM_EVENTS; e++) begin
        ev_cfg[e]   <= '0;
        cooldown[e] <= '0;
      end
      peak_found <= '0;
    end else begin
      for (int e = 0; e < NUM_EVENTS; e++) begin
        if (wr_en && (wr_addr == EVT_W'(e))) begin
          ev_cfg[e] <= wr_data;
        end
        if (is_tick && (cooldown[e] != '0)) begin
          cooldown[e] <= cooldown[e] - COOLDOWN_BITS'(1);
        end else if (closing && fire[e]) begin
          cooldown[e] <= reload[e];
        end
      end
      // The closing bin is folded into the snapshot; tracking starts afresh.
      if (closing) begin
        peak_found <= '0;
      end else begin
        peak_found <= peak_found | hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < NUM_EVENTS; e++) begin
      if (hit[e]) begin
        best_bin[e]   <= bin_index;
        best_value[e] <= mag;
      end
    end
  end

endmodule

// ===== design/sbped_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector back end
// Takes one frame snapshot at a time and emits its fired events in ascending
// event order, one item per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module sbped_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               fq_empty,
  input  sbped_pkg::frame_t  fq_frame,
  output logic               fq_pop,
  input  logic               out_full,
  output logic               out_push,
  output sbped_pkg::result_t out_item
);

  import sbped_pkg::*;

  frame_t                cur;
  logic                  cur_valid;
  logic [EVT_W-1:0]      sel;
  logic [MAX_EVENTS-1:0] remaining;
  logic                  last;

  always_comb begin
    sel = '0;
    for (int e = MAX_EVENTS - 1; e >= 0; e--) begin
      if (cur.mask[e]) begin
        sel = EVT_W'(e);
      end
    end
  end

  assign remaining = cur.mask & ~(MAX_EVENTS'(1) << sel);
  assign last      = (remaining == '0);
  assign out_push  = cur_valid && !out_full;
  assign fq_pop    = !fq_empty && (!cur_valid || (out_push && last));

  assign out_item.event_index = sel;
  assign out_item.peak_bin    = cur.bin[sel];
  assign out_item.peak_value  = cur.value[sel];
  assign out_item.last_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (fq_pop) begin
      cur_valid <= 1'b1;
    end else if (out_push && last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fq_pop) begin
      cur <= fq_frame;
    end else if (out_push) begin
      cur.mask <= remaining;
    end
  end

endmodule

// ===== design/spectral_band_peak_event_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral band peak event detector
// Tracks per-event spectral peaks over each frame of bins and reports every
// event that fired when the frame closes.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  input     push / full        action, bin_index, magnitude, frame_end
//  result    pop / empty        event_index, peak_bin, peak_value, last_of_run
//  config    wr_en              wr_addr, wr_data
//
// The front end takes one item every cycle while full is low; bins and ticks
// update all events in parallel. The back end emits a frame's fired events
// one result per cycle while the result queue has room. A four-entry frame
// queue lets bins keep streaming while results drain; full rises only when
// that queue is full. Reset is synchronous and clears all control state.
// ----------------------------------------------------------------------------
module spectral_band_peak_event_detector_top #(
  parameter int NUM_EVENTS    = 8,
  parameter int NUM_BINS      = 1024,
  parameter int SAMPLE_BITS   = 16,
  parameter int COOLDOWN_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        action,
  input  logic [sbped_pkg::BIN_W-1:0] bin_index,
  input  logic [sbped_pkg::MAG_W-1:0] magnitude,
  input  logic                        frame_end,
  output logic                        empty,
  input  logic                        pop,
  output logic [sbped_pkg::EVT_W-1:0] event_index,
  output logic [sbped_pkg::BIN_W-1:0] peak_bin,
  output logic [sbped_pkg::MAG_W-1:0] peak_value,
  output logic                        last_of_run,
  input  logic                        wr_en,
  input  logic [sbped_pkg::EVT_W-1:0] wr_addr,
  input  logic [sbped_pkg::CFG_W-1:0] wr_data
);

  import sbped_pkg::*;

  localparam int FQ_DEPTH  = 4;
  localparam int OUT_DEPTH = 2;

  logic    accept;
  logic    fq_push;
  logic    fq_full;
  logic    fq_pop;
  logic    fq_empty;
  frame_t  fq_in;
  frame_t  fq_out;
  logic    out_push;
  logic    out_full;
  result_t out_in;
  result_t out_head;

  assign full   = fq_full;
  assign accept = push && !fq_full;

  sbped_front #(
    .NUM_EVENTS    (NUM_EVENTS),
    .NUM_BINS      (NUM_BINS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COOLDOWN_BITS (COOLDOWN_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (action),
    .bin_index (bin_index),
    .magnitude (magnitude),
    .frame_end (frame_end),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .fq_push   (fq_push),
    .fq_frame  (fq_in)
  );

  sbped_queue #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (FQ_DEPTH)
  ) u_frame_q (
    .clk      (clk),
    .rst      (rst),
    .push     (fq_push),
    .data_in  (fq_in),
    .full     (fq_full),
    .pop      (fq_pop),
    .empty    (fq_empty),
    .data_out (fq_out)
  );

  sbped_back u_back (
    .clk      (clk),
    .rst      (rst),
    .fq_empty (fq_empty),
    .fq_frame (fq_out),
    .fq_pop   (fq_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_item (out_in)
  );

  sbped_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .data_in  (out_in),
    .full     (out_full),
    .pop      (pop),
    .empty    (empty),
    .data_out (out_head)
  );

  assign event_index = out_head.event_index;
  assign peak_bin    = out_head.peak_bin;
  assign peak_value  = out_head.peak_value;
  assign last_of_run = out_head.last_of_run;

  // A snapshot is only taken when the frame queue had room for it.
  a_fq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fq_push |-> !fq_full)
    else $error("frame snapshot pushed into a full queue");

  // Snapshots always carry at least one fired event.
  a_fq_nonzero: assert property (@(posedge clk) disable iff (rst)
    fq_push |-> (fq_in.mask != '0))
    else $error("empty frame snapshot queued");

  // Only events inside the configured count can fire.
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (32'(out_in.event_index) < NUM_EVENTS))
    else $error("result for an event beyond the configured count");

  // Reset leaves both queues drained.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not drained after reset");

endmodule
